>>> design/moving_average_deadband_filter_macros.svh
// Assertion macros for the moving-average deadband filter.
// Included by the RTL file that carries concurrent assertions; depends on nothing.
`ifndef MOVING_AVERAGE_DEADBAND_FILTER_MACROS_SVH
`define MOVING_AVERAGE_DEADBAND_FILTER_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset.
`define MADF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every clock edge, reset included.
`define MADF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define MADF_ASSERT(lbl, clk, rst_n, prop)
`define MADF_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> design/madf_pkg.sv
// Shared types and constants of the moving-average deadband filter.
// No dependencies; used by the channel interfaces and the top level.
package madf_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int THRESHOLD_W  = 10;
    localparam int THRESHOLD_RST = 4;

    typedef logic [SAMPLE_W-1:0]    t_sample;
    typedef logic [THRESHOLD_W-1:0] t_threshold;

endpackage

>>> design/madf_if.sv
// Valid/ready channel interfaces of the moving-average deadband filter.
// Depends on madf_pkg for the payload types.
interface madf_sample_if import madf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface madf_result_if import madf_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    raw_changed;
    t_sample change_amount;
    t_sample average_value;
    t_sample filtered_value;
    logic    filtered_changed;

    modport source (output valid, output raw_changed, output change_amount,
                    output average_value, output filtered_value, output filtered_changed,
                    input ready);
    modport sink   (input valid, input raw_changed, input change_amount,
                    input average_value, input filtered_value, input filtered_changed,
                    output ready);
endinterface

>>> design/madf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module madf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> design/moving_average_deadband_filter.sv
// Moving-average filter with deadband hysteresis for 10-bit potentiometer samples.
// Depends on madf_pkg, the channel interfaces in madf_if.sv and madf_ram.
//
// Usage:
//   i_sample_ch  - valid/ready input, one 10-bit sample per transfer.
//   o_result_ch  - valid/ready output, exactly one result per sample: raw change flag,
//                  absolute change, ring mean, held filtered value, filtered change flag.
//   i_cfg_wr_en / i_cfg_wr_data - writes the deadband threshold; write only while idle.
// A taken sample passes through stage 1 and the result register to o_result_ch.
// Throughput: one sample per cycle while o_result_ch.ready is high. The history
//   ring sits in a RAM: the old entry is read as the sample is taken and overwritten
//   from stage 1; a same-entry read and write in one cycle is forwarded.
// The ring mean is the running total times a fixed reciprocal, one multiplier.
// Reset: threshold 4, previous sample, total and held value zero; per-entry valid bits
//   make unwritten ring entries read as zero, so no clearing pass is needed.
// Stall: the result register holds while o_result_ch.ready is low; one more sample may
//   be taken and waits behind it, after which i_sample_ch.ready drops.
module moving_average_deadband_filter import madf_pkg::*; #(
    parameter int AVERAGE_DEPTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  t_threshold           i_cfg_wr_data,
    madf_sample_if.sink          i_sample_ch,
    madf_result_if.source        o_result_ch
);
    `include "moving_average_deadband_filter_macros.svh"

    localparam int PW    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int TW    = $clog2(AVERAGE_DEPTH) + SAMPLE_W;
    localparam int SH    = TW + $clog2(AVERAGE_DEPTH);
    localparam int MW    = TW + 1;
    localparam int PRODW = TW + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
    localparam logic [PW-1:0] LAST_POS = PW'(AVERAGE_DEPTH - 1);
    localparam logic [TW-1:0] TOTAL_MAX = TW'(((1 << SAMPLE_W) - 1) * AVERAGE_DEPTH);

    // Configuration
    t_threshold r_threshold;

    // Front: sample intake and ring position
    t_sample        r_prev;
    logic [PW-1:0]  r_pos;
    logic [PW-1:0]  n_pos;
    logic           in_fire;

    // Stage 1: item waiting for the ring read
    logic           r_s1_valid;
    logic [PW-1:0]  r_s1_pos;
    t_sample        r_s1_wdata;
    logic           r_s1_raw;
    t_sample        r_s1_change;
    logic           r_fwd;
    t_sample        r_fwd_data;

    // Stage 2: total, mean, deadband
    logic [TW-1:0]      r_total;
    logic [TW-1:0]      n_total;
    t_sample            r_held;
    t_sample            ram_rd_data;
    t_sample            old_entry;
    logic [PRODW-1:0]   prod;
    t_sample            avg;
    t_sample            held_diff;
    logic               update_held;
    logic               s2_fire;
    logic [AVERAGE_DEPTH-1:0] r_ring_vld;

    // Result register
    logic    r_out_valid;
    logic    r_out_raw;
    t_sample r_out_change;
    t_sample r_out_avg;
    t_sample r_out_filt;
    logic    r_out_fchg;

    t_sample sample_diff;

    assign s2_fire = r_s1_valid && (!r_out_valid || o_result_ch.ready);
    assign i_sample_ch.ready = !r_s1_valid || s2_fire;
    assign in_fire = i_sample_ch.valid && i_sample_ch.ready;

    assign n_pos = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
    assign sample_diff = (i_sample_ch.sample >= r_prev) ? i_sample_ch.sample - r_prev
                                                        : r_prev - i_sample_ch.sample;

    madf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (AVERAGE_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (s2_fire),
        .i_wr_addr (r_s1_pos),
        .i_wr_data (r_s1_wdata),
        .i_rd_en   (in_fire),
        .i_rd_addr (n_pos),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        if (r_fwd) begin
            old_entry = r_fwd_data;
        end else if (r_ring_vld[r_s1_pos]) begin
            old_entry = ram_rd_data;
        end else begin
            old_entry = '0;
        end
        n_total   = r_total - TW'(old_entry) + TW'(r_s1_wdata);
        // floor(total / depth) via rounded-up reciprocal, exact over the total's range
        prod      = PRODW'(n_total) * PRODW'(RECIP_M);
        avg       = prod[SH +: SAMPLE_W];
        held_diff = (r_held >= avg) ? r_held - avg : avg - r_held;
        update_held = held_diff > r_threshold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= t_threshold'(THRESHOLD_RST);
            r_prev      <= '0;
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_total     <= '0;
            r_held      <= '0;
            r_ring_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_threshold <= i_cfg_wr_data;
            end

            if (in_fire) begin
                r_prev     <= i_sample_ch.sample;
                r_pos      <= n_pos;
                r_s1_valid <= 1'b1;
                // the item ahead writes the entry this transfer reads in the same cycle
                r_fwd      <= s2_fire && (r_s1_pos == n_pos);
            end else if (s2_fire) begin
                r_s1_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end

            if (s2_fire) begin
                r_total              <= n_total;
                r_ring_vld[r_s1_pos] <= 1'b1;
                if (update_held) begin
                    r_held <= avg;
                end
                r_out_valid <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pos    <= n_pos;
            r_s1_wdata  <= r_prev;
            r_s1_raw    <= (sample_diff != '0);
            r_s1_change <= sample_diff;
            r_fwd_data  <= r_s1_wdata;
        end
        if (s2_fire) begin
            r_out_raw    <= r_s1_raw;
            r_out_change <= r_s1_change;
            r_out_avg    <= avg;
            r_out_filt   <= update_held ? avg : r_held;
            r_out_fchg   <= update_held;
        end
    end

    assign o_result_ch.valid            = r_out_valid;
    assign o_result_ch.raw_changed      = r_out_raw;
    assign o_result_ch.change_amount    = r_out_change;
    assign o_result_ch.average_value    = r_out_avg;
    assign o_result_ch.filtered_value   = r_out_filt;
    assign o_result_ch.filtered_changed = r_out_fchg;

    `MADF_ASSERT(a_fwd_needs_item, i_clk, i_rst_n, r_fwd |-> r_s1_valid)
    `MADF_ASSERT(a_total_in_range, i_clk, i_rst_n, r_total <= TOTAL_MAX)
    `MADF_ASSERT(a_pos_in_range, i_clk, i_rst_n, r_pos <= LAST_POS)
    `MADF_ASSERT(a_accept_loads_stage, i_clk, i_rst_n, in_fire |=> r_s1_valid)
    `MADF_ASSERT(a_update_takes_mean, i_clk, i_rst_n,
        (r_out_valid && r_out_fchg) |-> (r_out_filt == r_out_avg))
    `MADF_ASSERT_ALWAYS(a_reset_clears_ring, i_clk, !i_rst_n |=> (r_ring_vld == '0))
endmodule
